@@ src/oor_pkg.sv @@
// Shared types and codes for the out-of-range alarm point.
// Used by the configuration block, the evaluation core, the result queue and the checker.
package oor_pkg;

    // Operation codes of an event.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_ACK    = 2'd2;
    localparam logic [1:0] OP_MAINT  = 2'd3;

    // Point states.
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_HIGH   = 2'd1;
    localparam logic [1:0] ST_LOW    = 2'd2;
    localparam logic [1:0] ST_FAULT  = 2'd3;

    // Result codes beyond the state notifications.
    localparam logic [2:0] EV_ACK = 3'd4;
    localparam logic [2:0] EV_ESC = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_ALARM_HI       = 3'd0;
    localparam logic [2:0] REG_ALARM_LO       = 3'd1;
    localparam logic [2:0] REG_DEADBAND       = 3'd2;
    localparam logic [2:0] REG_ALARM_DELAY    = 3'd3;
    localparam logic [2:0] REG_NORMAL_DELAY   = 3'd4;
    localparam logic [2:0] REG_ESCALATE_AFTER = 3'd5;

    // Normal delay value that selects the alarm delay instead.
    localparam logic [31:0] SAME_AS_ALARM = 32'hFFFF_FFFF;

    // Most results one event can produce, and the result queue depth.
    localparam int MAX_RES     = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] alarm_hi;
        logic [31:0] alarm_lo;
        logic [30:0] deadband;
        logic [31:0] alarm_delay;
        logic [31:0] normal_delay;
        logic [31:0] escalate_after;
    } oor_cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now;
        logic [31:0] sample_value;
        logic        bad_sample;
        logic        maint_on;
    } oor_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] note_time;
        logic [31:0] note_value;
        logic [1:0]  point_state;
        logic        last_note;
    } oor_note_t;

endpackage

@@ src/oor_cfg.sv @@
// APB-style configuration registers of the out-of-range alarm point.
// Depends on oor_pkg for the register indexes and the configuration struct.
module oor_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output oor_pkg::oor_cfg_t cfg
);

    oor_pkg::oor_cfg_t cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes; writes beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_hi       <= 32'd0;
            cfg_reg.alarm_lo       <= 32'd0;
            cfg_reg.deadband       <= 31'd0;
            cfg_reg.alarm_delay    <= 32'd0;
            cfg_reg.normal_delay   <= oor_pkg::SAME_AS_ALARM;
            cfg_reg.escalate_after <= 32'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                oor_pkg::REG_ALARM_HI:       cfg_reg.alarm_hi       <= pwdata;
                oor_pkg::REG_ALARM_LO:       cfg_reg.alarm_lo       <= pwdata;
                oor_pkg::REG_DEADBAND:       cfg_reg.deadband       <= pwdata[30:0];
                oor_pkg::REG_ALARM_DELAY:    cfg_reg.alarm_delay    <= pwdata;
                oor_pkg::REG_NORMAL_DELAY:   cfg_reg.normal_delay   <= pwdata;
                oor_pkg::REG_ESCALATE_AFTER: cfg_reg.escalate_after <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            oor_pkg::REG_ALARM_HI:       prdata = cfg_reg.alarm_hi;
            oor_pkg::REG_ALARM_LO:       prdata = cfg_reg.alarm_lo;
            oor_pkg::REG_DEADBAND:       prdata = {1'b0, cfg_reg.deadband};
            oor_pkg::REG_ALARM_DELAY:    prdata = cfg_reg.alarm_delay;
            oor_pkg::REG_NORMAL_DELAY:   prdata = cfg_reg.normal_delay;
            oor_pkg::REG_ESCALATE_AFTER: prdata = cfg_reg.escalate_after;
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

@@ src/oor_core.sv @@
// Evaluation core: point state registers and the single-pass event evaluation.
// Depends on oor_pkg for codes, the configuration struct, the item and the note types.
module oor_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  oor_pkg::oor_cfg_t cfg,
    input  logic              step,
    input  oor_pkg::oor_item_t item,
    output oor_pkg::oor_note_t notes [oor_pkg::MAX_RES],
    output logic [1:0]        note_cnt
);

    // Working copy of the point state while an event is evaluated.
    typedef struct packed {
        logic [1:0]       ps;
        logic [1:0]       lns;
        logic             pv;
        logic [1:0]       pt;
        logic [31:0]      pst;
        logic [31:0]      ept;
        logic             unack;
        logic             esc;
        logic             maint;
        logic [1:0]       n;
        logic [2:0][2:0]  ev;
        logic [2:0][1:0]  nps;
    } eval_t;

    logic [1:0]  ps_reg, lns_reg, pt_reg;
    logic        pv_reg, unack_reg, esc_reg, maint_reg;
    logic [31:0] pst_reg, ept_reg, nt_reg, lv_reg;

    eval_t       e;
    logic [31:0] nt_next, lv_next;
    logic        is_new;

    logic signed [33:0] x_ext, hl_ext, ll_ext, hi_ret, lo_ret;

    // Appends one result if there is still room for it.
    function automatic eval_t emit(eval_t s, logic [2:0] code);
        if (s.n < 2'd3) begin
            s.ev[s.n]  = code;
            s.nps[s.n] = s.ps;
            s.n        = s.n + 2'd1;
        end
        return s;
    endfunction

    // Reports the current state; an alarm state opens a new episode.
    function automatic eval_t notify(eval_t s, logic [31:0] now);
        s     = emit(s, {1'b0, s.ps});
        s.lns = s.ps;
        if (s.ps == oor_pkg::ST_HIGH || s.ps == oor_pkg::ST_LOW) begin
            s.unack = 1'b1;
            s.ept   = now;
            s.esc   = 1'b0;
        end
        return s;
    endfunction

    // Moves to a new state, silently while in maintenance.
    function automatic eval_t go_to(eval_t s, logic [1:0] to, logic [31:0] now);
        s.ps = to;
        s.pv = 1'b0;
        if (!s.maint) begin
            s = notify(s, now);
        end
        return s;
    endfunction

    // Limit thresholds in wider arithmetic so the deadband never overflows.
    assign x_ext  = $signed({{2{item.sample_value[31]}}, item.sample_value});
    assign hl_ext = $signed({{2{cfg.alarm_hi[31]}}, cfg.alarm_hi});
    assign ll_ext = $signed({{2{cfg.alarm_lo[31]}}, cfg.alarm_lo});
    assign hi_ret = hl_ext - $signed({3'b000, cfg.deadband});
    assign lo_ret = ll_ext + $signed({3'b000, cfg.deadband});

    // Single pass over one event: transitions, then acknowledge or maintenance switch, then escalation.
    always_comb begin : eval_comb
        logic        tv;
        logic [1:0]  tgt;
        logic        run_tmr;
        logic [31:0] dly;

        e.ps    = ps_reg;
        e.lns   = lns_reg;
        e.pv    = pv_reg;
        e.pt    = pt_reg;
        e.pst   = pst_reg;
        e.ept   = ept_reg;
        e.unack = unack_reg;
        e.esc   = esc_reg;
        e.maint = maint_reg;
        e.n     = 2'd0;
        e.ev    = '0;
        e.nps   = '0;
        nt_next = nt_reg;
        lv_next = lv_reg;
        tv      = 1'b0;
        tgt     = oor_pkg::ST_NORMAL;
        run_tmr = 1'b1;
        dly     = cfg.alarm_delay;
        is_new  = (item.now >= nt_reg);

        if (is_new) begin
            nt_next = item.now;

            // Sample handling: fault forcing and limit condition tracking.
            if (item.opcode == oor_pkg::OP_SAMPLE) begin
                lv_next = item.sample_value;
                if (item.bad_sample) begin
                    run_tmr = 1'b0;
                    if (e.ps != oor_pkg::ST_FAULT) begin
                        e = go_to(e, oor_pkg::ST_FAULT, item.now);
                    end
                    e.pv = 1'b0;
                end else begin
                    if (e.ps == oor_pkg::ST_FAULT) begin
                        e = go_to(e, oor_pkg::ST_NORMAL, item.now);
                    end
                    unique case (e.ps)
                        oor_pkg::ST_NORMAL: begin
                            if (x_ext > hl_ext) begin
                                tv = 1'b1; tgt = oor_pkg::ST_HIGH;
                            end else if (x_ext < ll_ext) begin
                                tv = 1'b1; tgt = oor_pkg::ST_LOW;
                            end
                        end
                        oor_pkg::ST_HIGH: begin
                            if (x_ext < ll_ext) begin
                                tv = 1'b1; tgt = oor_pkg::ST_LOW;
                            end else if (x_ext < hi_ret) begin
                                tv = 1'b1; tgt = oor_pkg::ST_NORMAL;
                            end
                        end
                        oor_pkg::ST_LOW: begin
                            if (x_ext > hl_ext) begin
                                tv = 1'b1; tgt = oor_pkg::ST_HIGH;
                            end else if (x_ext > lo_ret) begin
                                tv = 1'b1; tgt = oor_pkg::ST_NORMAL;
                            end
                        end
                        default: ;
                    endcase
                    if (!tv) begin
                        e.pv = 1'b0;
                    end else if (!e.pv || tgt != e.pt) begin
                        e.pv  = 1'b1;
                        e.pt  = tgt;
                        e.pst = item.now;
                    end
                end
            end

            // Delay timer of the pending transition.
            if (e.pt == oor_pkg::ST_NORMAL && cfg.normal_delay != oor_pkg::SAME_AS_ALARM) begin
                dly = cfg.normal_delay;
            end
            if (run_tmr && e.ps != oor_pkg::ST_FAULT && e.pv) begin
                if ((item.now - e.pst) >= dly) begin
                    e = go_to(e, e.pt, item.now);
                end
            end

            // Acknowledge and maintenance switch.
            if (item.opcode == oor_pkg::OP_ACK) begin
                if (e.unack) begin
                    e.unack = 1'b0;
                    if (!e.maint) begin
                        e = emit(e, oor_pkg::EV_ACK);
                    end
                end
            end else if (item.opcode == oor_pkg::OP_MAINT) begin
                if (item.maint_on) begin
                    e.maint = 1'b1;
                end else if (e.maint) begin
                    e.maint = 1'b0;
                    if (e.ps != e.lns) begin
                        e = notify(e, item.now);
                    end
                end
            end

            // One escalation per unacknowledged episode.
            if (e.unack && !e.esc && !e.maint && cfg.escalate_after != 32'd0 &&
                (item.now - e.ept) >= cfg.escalate_after) begin
                e     = emit(e, oor_pkg::EV_ESC);
                e.esc = 1'b1;
            end
        end
    end

    // Result slots handed to the queue.
    always_comb begin
        for (int i = 0; i < oor_pkg::MAX_RES; i++) begin
            notes[i].event_res   = e.ev[i];
            notes[i].note_time   = item.now;
            notes[i].note_value  = lv_next;
            notes[i].point_state = e.nps[i];
            notes[i].last_note   = (2'(i) == e.n - 2'd1);
        end
    end

    assign note_cnt = e.n;

    // State update when the event leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg    <= oor_pkg::ST_NORMAL;
            lns_reg   <= oor_pkg::ST_NORMAL;
            pv_reg    <= 1'b0;
            pt_reg    <= oor_pkg::ST_NORMAL;
            pst_reg   <= 32'd0;
            ept_reg   <= 32'd0;
            nt_reg    <= 32'd0;
            lv_reg    <= 32'd0;
            unack_reg <= 1'b0;
            esc_reg   <= 1'b0;
            maint_reg <= 1'b0;
        end else if (step) begin
            ps_reg    <= e.ps;
            lns_reg   <= e.lns;
            pv_reg    <= e.pv;
            pt_reg    <= e.pt;
            pst_reg   <= e.pst;
            ept_reg   <= e.ept;
            nt_reg    <= nt_next;
            lv_reg    <= lv_next;
            unack_reg <= e.unack;
            esc_reg   <= e.esc;
            maint_reg <= e.maint;
        end
    end

endmodule

@@ src/oor_resq.sv @@
// Result queue: takes up to three notes per cycle while it has room and delivers one per cycle while m_ready is high.
// Depends on oor_pkg for the note type and the queue depth.
module oor_resq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  oor_pkg::oor_note_t push_notes [oor_pkg::MAX_RES],
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output oor_pkg::oor_note_t head
);

    oor_pkg::oor_note_t mem_reg [oor_pkg::QUEUE_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [2:0] after_pop;

    assign m_valid   = (count_reg != 3'd0);
    assign pop       = m_valid && m_ready;
    assign head      = mem_reg[rd_ptr_reg];
    assign after_pop = count_reg - {2'b00, pop};
    // A full event needs three free entries.
    assign room      = (after_pop <= 3'd1);

    assign wr_ptr_next = wr_ptr_reg + push_cnt;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = after_pop + {1'b0, push_cnt};

    // Entry storage.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < oor_pkg::MAX_RES; i++) begin
            if (2'(i) < push_cnt) begin
                mem_reg[2'(wr_ptr_reg + 2'(i))] <= push_notes[i];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/out_of_range_alarm_point_top.sv @@
// Top level of the out-of-range alarm point: input register, evaluation core, result queue.
// Depends on oor_pkg, oor_cfg, oor_core and oor_resq.

// An event is taken into the input register on s_valid and s_ready and is evaluated there
// once the result queue has room for a full event; its zero to three notifications are then
// written together into a four-entry result queue, and m_valid comes from the registered
// queue count, so the first notification is seen after the queue is written. An event is
// taken every cycle while the queue has room for a full event, so the sustained rate is set
// by the m_ port, which delivers one notification per cycle while m_ready is high; an event
// produces at most three results. The user must write configuration registers over the APB
// port only while no event is in flight; the block does not enforce this.
module out_of_range_alarm_point_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // event input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_now,
    input  logic [31:0] s_sample_value,
    input  logic        s_bad_sample,
    input  logic        s_maint_on,
    // notification output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [31:0] m_note_time,
    output logic [31:0] m_note_value,
    output logic [1:0]  m_point_state,
    output logic        m_last_note
);

    oor_pkg::oor_cfg_t  cfg;
    oor_pkg::oor_item_t item_reg;
    oor_pkg::oor_note_t notes [oor_pkg::MAX_RES];
    oor_pkg::oor_note_t head;
    logic               in_valid_reg, in_valid_next;
    logic               room, step, s_accept;
    logic [1:0]         note_cnt;
    logic [1:0]         push_cnt;

    assign step     = in_valid_reg && room;
    assign s_ready  = !in_valid_reg || room;
    assign s_accept = s_valid && s_ready;
    assign push_cnt = step ? note_cnt : 2'd0;

    // Input register occupancy.
    assign in_valid_next = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.opcode       <= s_opcode;
            item_reg.now          <= s_now;
            item_reg.sample_value <= s_sample_value;
            item_reg.bad_sample   <= s_bad_sample;
            item_reg.maint_on     <= s_maint_on;
        end
    end

    oor_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    oor_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step     (step),
        .item     (item_reg),
        .notes    (notes),
        .note_cnt (note_cnt)
    );

    oor_resq u_resq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push_notes (notes),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    // Result channel payload.
    assign m_event_res   = head.event_res;
    assign m_note_time   = head.note_time;
    assign m_note_value  = head.note_value;
    assign m_point_state = head.point_state;
    assign m_last_note   = head.last_note;

endmodule

@@ src/oor_checker.sv @@
// Port-level checks of the out-of-range alarm point result channel.
// Depends on oor_pkg for the result codes; bound to out_of_range_alarm_point_top.
module oor_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_event_res,
    input logic [31:0] m_note_time,
    input logic [1:0]  m_point_state,
    input logic        m_last_note
);

    // A stalled transaction holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_note_time))
        else $error("result changed while stalled");

    // Escalation is always the final notification of its event.
    a_esc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == oor_pkg::EV_ESC |-> m_last_note)
        else $error("escalation not marked final");

    // A state notification reports the state it names.
    a_state_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != oor_pkg::EV_ACK && m_event_res != oor_pkg::EV_ESC
        |-> m_point_state == m_event_res[1:0])
        else $error("state notification disagrees with point state");

    // The results of one event follow each other without a gap.
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_note |=> m_valid && m_note_time == $past(m_note_time))
        else $error("event results split");

endmodule

bind out_of_range_alarm_point_top oor_checker u_oor_checker (.*);
